### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

### rtl/core/baro_pkg.sv
`timescale 1ns / 1ps
package baro_pkg;

   typedef struct packed {
      logic        func;
      logic [18:0] raw_value;
      logic [31:0] sample_time;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] pressure_pa;
      logic [27:0] temperature_tenths;
      logic        next_is_temperature;
      logic [31:0] stamp_out;
   } rsp_type;

   localparam logic [1:0] ST_TEMP_OK  = 2'd0;
   localparam logic [1:0] ST_PRES_OK  = 2'd1;
   localparam logic [1:0] ST_TEMP_ERR = 2'd2;
   localparam logic [1:0] ST_PRES_ERR = 2'd3;

   localparam logic [2:0] REG_CAL_A   = 3'd0;
   localparam logic [2:0] REG_CAL_B   = 3'd1;
   localparam logic [2:0] REG_CAL_C   = 3'd2;
   localparam logic [2:0] REG_OSS     = 3'd3;
   localparam logic [2:0] REG_REFRESH = 3'd4;
   localparam logic [2:0] REG_MIN     = 3'd5;
   localparam logic [2:0] REG_MAX     = 3'd6;

   // Sequencer: one microstep per state; many use the shared multiplier or divider.
   typedef enum logic [4:0] {
      S_IDLE,
      S_T0, S_T1, S_T2, S_TDIV, S_T3,
      S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8,
      S_PDIV, S_P9, S_P10, S_P11, S_P12, S_P13,
      S_OUT
   } state_type;

endpackage

### rtl/core/baro_sensor_compensation.sv
`timescale 1ns / 1ps
// From accept to the earliest result beat, the divider pass dominates; a zero divisor on a
// temperature item or a zero B4 on a pressure item skips the divider.
// Throughput: one item at a time; req_stall is high from accept until the result is taken.
// Multiplications go one per cycle through a single shared 32x32 multiplier.
// Synchronous active-high reset clears the sequencer, state terms and configuration registers
// to their reset values; the working, divider and payload registers have no reset.
module baro_sensor_compensation #(
   parameter int COUNT_MAX = 255
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  baro_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output baro_pkg::rsp_type    rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [63:0]          csr_wdata
);
   import baro_pkg::*;
   `include "assert_macros.svh"

   localparam logic [7:0] CountMax = 8'(COUNT_MAX);

   // configuration registers
   logic [63:0] cal_a_ff, cal_b_ff;
   logic [31:0] cal_c_ff;
   logic [1:0]  oss_ff;
   logic [7:0]  refresh_ff;
   logic [17:0] min_ff, max_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_a_ff <= '0; cal_b_ff <= '0; cal_c_ff <= '0; oss_ff <= '0;
         refresh_ff <= 8'd1; min_ff <= 18'd30000; max_ff <= 18'd110000;
      end else if (csr_valid) begin
         case (csr_index)
            REG_CAL_A:   cal_a_ff   <= csr_wdata;
            REG_CAL_B:   cal_b_ff   <= csr_wdata;
            REG_CAL_C:   cal_c_ff   <= csr_wdata[31:0];
            REG_OSS:     oss_ff     <= csr_wdata[1:0];
            REG_REFRESH: refresh_ff <= csr_wdata[7:0];
            REG_MIN:     min_ff     <= csr_wdata[17:0];
            REG_MAX:     max_ff     <= csr_wdata[17:0];
            default: ;
         endcase
      end
   end

   // calibration fields, extended to 32 bits
   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = {{16{cal_a_ff[63]}}, cal_a_ff[63:48]};
   assign ac2 = {{16{cal_a_ff[47]}}, cal_a_ff[47:32]};
   assign ac3 = {{16{cal_a_ff[31]}}, cal_a_ff[31:16]};
   assign ac4 = {16'd0, cal_a_ff[15:0]};
   assign ac5 = {16'd0, cal_b_ff[63:48]};
   assign ac6 = {16'd0, cal_b_ff[47:32]};
   assign b1  = {{16{cal_b_ff[31]}}, cal_b_ff[31:16]};
   assign b2  = {{16{cal_b_ff[15]}}, cal_b_ff[15:0]};
   assign mc  = {{16{cal_c_ff[31]}}, cal_c_ff[31:16]};
   assign md  = {{16{cal_c_ff[15]}}, cal_c_ff[15:0]};

   state_type state_ff, state_in;
   req_type   req_ff;
   rsp_type   rsp_ff, rsp_in;
   logic [31:0] b5_ff, b5_in;
   logic [27:0] tt_ff, tt_in;
   logic [7:0]  cnt_ff, cnt_in;
   // working registers
   logic [31:0] r0_ff, r0_in, r1_ff, r1_in, r2_ff, r2_in, r3_ff, r3_in;
   logic [31:0] r4_ff, r4_in;

   // shared multiplier (low 32 bits)
   logic [31:0] mul_a, mul_b, mul_p;
   assign mul_p = mul_a * mul_b;

   // shared divider: unsigned restoring, one bit per cycle
   logic [31:0] dq_ff, dq_in, dr_ff, dr_in, dd_ff, dd_in;
   logic [5:0]  dc_ff, dc_in;
   logic [32:0] dtrial;
   assign dtrial = {dr_ff, dq_ff[31]} - {1'b0, dd_ff};

   function automatic logic [31:0] asr(input logic [31:0] v, input int n);
      asr = 32'($signed(v) >>> n);
   endfunction

   function automatic logic [31:0] neg(input logic [31:0] v);
      neg = 32'd0 - v;
   endfunction

   logic accept, rsp_fire;
   assign accept    = req_valid && !req_stall;
   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) state_in = req_data.func ? S_P0 : S_T0;
         S_T0:  state_in = S_T1;
         S_T1:  state_in = S_T2;
         S_T2:  state_in = (r1_ff == 32'd0) ? S_OUT : S_TDIV;
         S_TDIV: if (dc_ff == 6'd32) state_in = S_T3;
         S_T3:  state_in = S_OUT;
         S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6: state_in = state_type'(state_ff + 5'd1);
         S_P7:  state_in = S_P8;
         S_P8:  state_in = (r4_ff == 32'd0) ? S_OUT : S_PDIV;
         S_PDIV: if (dc_ff == 6'd32) state_in = S_P9;
         S_P9, S_P10, S_P11, S_P12: state_in = state_type'(state_ff + 5'd1);
         S_P13: state_in = S_OUT;
         S_OUT: if (rsp_fire) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath per step
   always_comb begin
      logic [31:0] t, p;
      logic signed [32:0] ps;
      r0_in = r0_ff; r1_in = r1_ff; r2_in = r2_ff; r3_in = r3_ff; r4_in = r4_ff;
      b5_in = b5_ff; tt_in = tt_ff; cnt_in = cnt_ff; rsp_in = rsp_ff;
      dq_in = dq_ff; dr_in = dr_ff; dd_in = dd_ff; dc_in = dc_ff;
      mul_a = 32'd0; mul_b = 32'd0;
      t = 32'd0; p = 32'd0; ps = '0;
      case (state_ff)
         // x1 = asr((ut - ac6) * ac5, 15)
         S_T0: begin
            mul_a = {16'd0, req_ff.raw_value[15:0]} - ac6; mul_b = ac5;
            r0_in = asr(mul_p, 15);
         end
         S_T1: r1_in = r0_ff + md;
         // den check, set up |mc<<11| / |den|
         S_T2: begin
            if (r1_ff == 32'd0) begin
               rsp_in = '{ST_TEMP_ERR, 32'd0, tt_ff, 1'b1, 32'd0};
            end else begin
               t = mc << 11;
               r2_in = {31'd0, t[31] ^ r1_ff[31]};
               dq_in = t[31] ? neg(t) : t;
               dd_in = r1_ff[31] ? neg(r1_ff) : r1_ff;
               dr_in = 32'd0; dc_in = 6'd0;
            end
         end
         S_TDIV, S_PDIV: if (dc_ff != 6'd32) begin
            if (!dtrial[32]) begin
               dr_in = dtrial[31:0]; dq_in = {dq_ff[30:0], 1'b1};
            end else begin
               dr_in = {dr_ff[30:0], dq_ff[31]}; dq_in = {dq_ff[30:0], 1'b0};
            end
            dc_in = dc_ff + 6'd1;
         end
         S_T3: begin
            t = r0_ff + (r2_ff[0] ? neg(dq_ff) : dq_ff);
            b5_in = t;
            tt_in = 28'(asr(t + 32'd8, 4));
            cnt_in = 8'd0;
            rsp_in = '{ST_TEMP_OK, 32'd0, tt_in, 1'b0, 32'd0};
         end
         // b6 and sq
         S_P0: begin
            r0_in = b5_ff - 32'd4000;
            mul_a = r0_in; mul_b = r0_in; r1_in = asr(mul_p, 12);
         end
         // x1 = asr(b2*sq,11)
         S_P1: begin mul_a = b2; mul_b = r1_ff; r2_in = asr(mul_p, 11); end
         // x3 = x1 + asr(ac2*b6,11); b3
         S_P2: begin
            mul_a = ac2; mul_b = r0_ff;
            t = r2_ff + asr(mul_p, 11);
            r2_in = asr(((ac1 << 2) + t << oss_ff) + 32'd2, 2);
         end
         S_P3: begin mul_a = ac3; mul_b = r0_ff; r3_in = asr(mul_p, 13); end
         S_P4: begin
            mul_a = b1; mul_b = r1_ff;
            r3_in = asr(r3_ff + asr(mul_p, 16) + 32'd2, 2);
         end
         S_P5: begin mul_a = ac4; mul_b = r3_ff + 32'd32768; r4_in = mul_p >> 15; end
         // b7
         S_P6: begin
            mul_a = {13'd0, req_ff.raw_value} - r2_ff;
            mul_b = 32'd50000 >> oss_ff;
            r1_in = mul_p;
         end
         S_P7: ;
         S_P8: begin
            if (r4_ff == 32'd0) begin
               rsp_in = '{ST_PRES_ERR, 32'd0, tt_ff, 1'b1, 32'd0};
            end else begin
               dq_in = r1_ff[31] ? r1_ff : (r1_ff << 1);
               dd_in = r4_ff; dr_in = 32'd0; dc_in = 6'd0;
            end
         end
         // p, then x1 = asr(p,8)^2
         S_P9: begin
            p = r1_ff[31] ? (dq_ff << 1) : dq_ff;
            r0_in = p;
            mul_a = asr(p, 8); mul_b = asr(p, 8); r2_in = mul_p;
         end
         S_P10: begin mul_a = r2_ff; mul_b = 32'd3038; r2_in = asr(mul_p, 16); end
         S_P11: begin mul_a = neg(32'd7357); mul_b = r0_ff; r3_in = asr(mul_p, 16); end
         S_P12: r0_in = r0_ff + asr(r2_ff + r3_ff + 32'd3791, 4);
         S_P13: begin
            ps = $signed({r0_ff[31], r0_ff});
            if (ps < $signed({15'd0, min_ff}) || ps > $signed({15'd0, max_ff})) begin
               rsp_in = '{ST_PRES_ERR, 32'd0, tt_ff, 1'b1, 32'd0};
            end else begin
               if (cnt_ff < CountMax) cnt_in = cnt_ff + 8'd1;
               rsp_in = '{ST_PRES_OK, r0_ff, tt_ff, (cnt_in >= refresh_ff),
                          req_ff.sample_time};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         b5_ff <= '0; tt_ff <= '0; cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         b5_ff <= b5_in; tt_ff <= tt_in; cnt_ff <= cnt_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_data;
      rsp_ff <= rsp_in;
      r0_ff <= r0_in; r1_ff <= r1_in; r2_ff <= r2_in; r3_ff <= r3_in; r4_ff <= r4_in;
      dq_ff <= dq_in; dr_ff <= dr_in; dd_ff <= dd_in; dc_ff <= dc_in;
   end

   `ASSERT_IMPL(a_busy_no_accept, clock, reset, state_ff != S_IDLE, req_stall, "accept while busy")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "rsp dropped")
   `ASSERT_IMPL(a_cnt_sat, clock, reset, 1'b1, cnt_ff <= CountMax, "counter over limit")
   `ASSERT_IMPL(a_div_bound, clock, reset, state_ff == S_TDIV || state_ff == S_PDIV, dc_ff <= 6'd32, "divider overrun")
endmodule
